// ===== rtl/dpad_pkg.sv =====
// ----------------------------------------------------------------------------
// dpad_pkg
// Shared codes and types for the gamepad text-entry decoder.
// ----------------------------------------------------------------------------
package dpad_pkg;

	// action codes
	localparam logic [2:0] ACT_NONE  = 3'd0;
	localparam logic [2:0] ACT_CHAR  = 3'd1;
	localparam logic [2:0] ACT_BACK  = 3'd2;
	localparam logic [2:0] ACT_ENTER = 3'd3;
	localparam logic [2:0] ACT_ESC   = 3'd4;

	// character classes
	localparam logic [1:0] CLS_LOWER  = 2'd0;
	localparam logic [1:0] CLS_UPPER  = 2'd1;
	localparam logic [1:0] CLS_DIGIT  = 2'd2;
	localparam logic [1:0] CLS_SYMBOL = 2'd3;

	// button codes
	localparam logic [3:0] BTN_LEFT  = 4'd0;
	localparam logic [3:0] BTN_RIGHT = 4'd1;
	localparam logic [3:0] BTN_UP    = 4'd2;
	localparam logic [3:0] BTN_DOWN  = 4'd3;
	localparam logic [3:0] BTN_AUX1  = 4'd4;
	localparam logic [3:0] BTN_AUX2  = 4'd5;
	localparam logic [3:0] BTN_A     = 4'd6;
	localparam logic [3:0] BTN_Y     = 4'd7;
	localparam logic [3:0] BTN_B     = 4'd8;

	typedef struct packed {
		logic [2:0] action_kind;
		logic [7:0] char_code;
		logic       next_char;
	} res_t;

	// class update request from the decoder
	typedef struct packed {
		logic       we;
		logic [1:0] cls;
	} cls_upd_t;

endpackage

// ===== rtl/dpad_evt_if.sv =====
// ----------------------------------------------------------------------------
// dpad_evt_if
// Button event channel: valid/ready with the event payload.
// ----------------------------------------------------------------------------
interface dpad_evt_if;
	logic       valid;
	logic       ready;
	logic [3:0] button;
	logic [7:0] last_char;
	logic       string_empty;

	modport source (output valid, output button, output last_char, output string_empty,
		input ready);
	modport sink (input valid, input button, input last_char, input string_empty,
		output ready);
endinterface

// ===== rtl/dpad_act_if.sv =====
// ----------------------------------------------------------------------------
// dpad_act_if
// Text-entry action channel: valid/ready with the action payload.
// ----------------------------------------------------------------------------
interface dpad_act_if;
	logic       valid;
	logic       ready;
	logic [2:0] action_kind;
	logic [7:0] char_code;
	logic       next_char;

	modport source (output valid, output action_kind, output char_code, output next_char,
		input ready);
	modport sink (input valid, input action_kind, input char_code, input next_char,
		output ready);
endinterface

// ===== rtl/dpad_decode.sv =====
// ----------------------------------------------------------------------------
// dpad_decode
// Combinational decode of one button event into an action and class update.
// ----------------------------------------------------------------------------
module dpad_decode (
	input  logic [3:0]        button,
	input  logic [7:0]        last_char,
	input  logic              string_empty,
	input  logic              addr_mode,
	input  logic [1:0]        cls,
	output dpad_pkg::res_t    res,
	output dpad_pkg::cls_upd_t upd
);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_EXCL  = 8'h21;
	localparam logic [7:0] CH_AT    = 8'h40;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LBRK  = 8'h5B;
	localparam logic [7:0] CH_BTICK = 8'h60;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_LBRC  = 8'h7B;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CASE_OFS = 8'h20;

	function automatic logic [7:0] first_of(input logic [1:0] c);
		logic [7:0] r;
		case (c)
			dpad_pkg::CLS_LOWER: r = CH_LA;
			dpad_pkg::CLS_UPPER: r = CH_UA;
			dpad_pkg::CLS_DIGIT: r = CH_0;
			default:             r = CH_EXCL;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] last_of(input logic [1:0] c);
		logic [7:0] r;
		case (c)
			dpad_pkg::CLS_LOWER: r = CH_LZ;
			dpad_pkg::CLS_UPPER: r = CH_UZ;
			dpad_pkg::CLS_DIGIT: r = CH_9;
			default:             r = CH_TILDE;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] step_up(input logic [1:0] c, input logic [7:0] ch);
		logic [7:0] r;
		r = ch + 8'd1;
		if (c == dpad_pkg::CLS_LOWER || c == dpad_pkg::CLS_UPPER) begin
			if (ch == CH_SPACE) r = first_of(c);
			else if (ch == last_of(c)) r = CH_SPACE;
		end else if (c == dpad_pkg::CLS_DIGIT) begin
			if (ch == CH_9 || ch == CH_DOT) r = CH_0;
		end else begin
			if (ch == CH_SLASH) r = CH_COLON;
			else if (ch == CH_AT) r = CH_LBRK;
			else if (ch == CH_BTICK) r = CH_LBRC;
			else if (ch == CH_TILDE) r = CH_EXCL;
		end
		return r;
	endfunction

	function automatic logic [7:0] step_down(input logic [1:0] c, input logic [7:0] ch);
		logic [7:0] r;
		r = ch - 8'd1;
		if (c == dpad_pkg::CLS_LOWER || c == dpad_pkg::CLS_UPPER) begin
			if (ch == CH_SPACE) r = last_of(c);
			else if (ch == first_of(c)) r = CH_SPACE;
		end else if (c == dpad_pkg::CLS_DIGIT) begin
			if (ch == CH_0 || ch == CH_DOT) r = CH_9;
		end else begin
			if (ch == CH_COLON) r = CH_SLASH;
			else if (ch == CH_LBRK) r = CH_AT;
			else if (ch == CH_LBRC) r = CH_BTICK;
			else if (ch == CH_EXCL) r = CH_TILDE;
		end
		return r;
	endfunction

	logic       fwd;
	logic [1:0] ncls;
	logic       is_letter_cls;

	assign fwd           = (button == dpad_pkg::BTN_Y);
	assign ncls          = fwd ? cls + 2'd1 : cls - 2'd1;
	assign is_letter_cls = (cls == dpad_pkg::CLS_LOWER) || (cls == dpad_pkg::CLS_UPPER);

	always_comb begin
		res = '0;
		upd = '0;
		upd.cls = ncls;
		case (button)
			dpad_pkg::BTN_LEFT: res.action_kind = dpad_pkg::ACT_BACK;
			dpad_pkg::BTN_RIGHT: begin
				res.action_kind = dpad_pkg::ACT_CHAR;
				res.next_char   = 1'b1;
				res.char_code   = is_letter_cls ? CH_SPACE : first_of(cls);
			end
			dpad_pkg::BTN_UP: begin
				res.action_kind = dpad_pkg::ACT_CHAR;
				res.next_char   = string_empty;
				res.char_code   = string_empty ? first_of(cls) : step_up(cls, last_char);
			end
			dpad_pkg::BTN_DOWN: begin
				res.action_kind = dpad_pkg::ACT_CHAR;
				res.next_char   = string_empty;
				res.char_code   = string_empty ? last_of(cls) : step_down(cls, last_char);
			end
			dpad_pkg::BTN_AUX1: res.action_kind = dpad_pkg::ACT_ENTER;
			dpad_pkg::BTN_AUX2: res.action_kind = dpad_pkg::ACT_ESC;
			dpad_pkg::BTN_A: begin
				if (!addr_mode && is_letter_cls) begin
					res.action_kind = dpad_pkg::ACT_CHAR;
					res.char_code   = CH_SPACE;
					res.next_char   = string_empty;
				end else if (addr_mode && !string_empty) begin
					res.action_kind = dpad_pkg::ACT_CHAR;
					res.char_code   = CH_DOT;
				end
			end
			dpad_pkg::BTN_Y, dpad_pkg::BTN_B: begin
				// digit class is locked in address mode
				if (!(cls == dpad_pkg::CLS_DIGIT && addr_mode)) begin
					upd.we          = 1'b1;
					res.action_kind = dpad_pkg::ACT_CHAR;
					res.next_char   = string_empty;
					res.char_code   = first_of(ncls);
					if (!string_empty && fwd && cls == dpad_pkg::CLS_LOWER) begin
						res.char_code = (last_char >= CH_LA && last_char <= CH_LZ)
							? last_char - CASE_OFS : last_char;
					end else if (!string_empty && !fwd && cls == dpad_pkg::CLS_UPPER) begin
						res.char_code = (last_char >= CH_UA && last_char <= CH_UZ)
							? last_char + CASE_OFS : last_char;
					end
				end
			end
			default: res = '0;
		endcase
	end

endmodule

// ===== rtl/dpad_character_entry_fsm_unit.sv =====
// ----------------------------------------------------------------------------
// dpad_character_entry_fsm_unit
// Gamepad text-entry decoder: button events in, text-entry actions out.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                | handshake
//  evt      | in  | button, last_char, string_empty        | valid/ready
//  act      | out | action_kind, char_code, next_char      | valid/ready
//  cfg      | in  | keyboard_mode                          | cfg_we only
//
//  one beat per cycle while act is ready; a beat passes the input register, then the result register
//  the class register is read and updated in the decode stage, so back-to-back
//  beats see each other's class changes in order
//  reset: empty pipeline, mode profile, class lower
//  a stalled result holds both stages; ready falls only when both are full
// ----------------------------------------------------------------------------
module dpad_character_entry_fsm_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_wdata,
	dpad_evt_if.sink          evt,
	dpad_act_if.source        act
);

	logic                 vld_s1;
	logic [3:0]           button_s1;
	logic [7:0]           last_char_s1;
	logic                 empty_s1;
	logic                 vld_s2;
	dpad_pkg::res_t       res_s2;
	logic                 mode_q;
	logic [1:0]           cls_q;
	dpad_pkg::res_t       res_d;
	dpad_pkg::cls_upd_t   upd;
	logic                 adv_s2;
	logic                 adv_s1;

	assign adv_s2    = !vld_s2 || act.ready;
	assign adv_s1    = vld_s1 && adv_s2;
	assign evt.ready = !vld_s1 || adv_s2;

	dpad_decode u_dec (
		.button       (button_s1),
		.last_char    (last_char_s1),
		.string_empty (empty_s1),
		.addr_mode    (mode_q),
		.cls          (cls_q),
		.res          (res_d),
		.upd          (upd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			mode_q <= 1'b0;
			cls_q  <= dpad_pkg::CLS_LOWER;
		end else begin
			if (evt.ready) vld_s1 <= evt.valid;
			if (adv_s2) vld_s2 <= vld_s1;
			if (cfg_we) begin
				mode_q <= cfg_wdata;
				cls_q  <= cfg_wdata ? dpad_pkg::CLS_DIGIT : dpad_pkg::CLS_LOWER;
			end else if (adv_s1 && upd.we) begin
				cls_q <= upd.cls;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (evt.valid && evt.ready) begin
			button_s1    <= evt.button;
			last_char_s1 <= evt.last_char;
			empty_s1     <= evt.string_empty;
		end
		if (adv_s1) res_s2 <= res_d;
	end

	assign act.valid       = vld_s2;
	assign act.action_kind = res_s2.action_kind;
	assign act.char_code   = res_s2.char_code;
	assign act.next_char   = res_s2.next_char;

`ifndef SYNTH
	// address mode keeps the class on digit
	a_addr_digit: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q |-> cls_q == dpad_pkg::CLS_DIGIT)
		else $error("class left digit in address mode");

	// a non-character action carries no code and no append flag
	a_no_char_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && res_s2.action_kind != dpad_pkg::ACT_CHAR)
			|-> (res_s2.char_code == 8'd0 && !res_s2.next_char))
		else $error("payload on non-character action");

	// mode write resets the class
	a_cfg_cls: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> cls_q == ($past(cfg_wdata) ? dpad_pkg::CLS_DIGIT : dpad_pkg::CLS_LOWER))
		else $error("class not reset by mode write");

	// a decoded beat reaches the result register while it is free
	a_s1_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !vld_s2) |=> vld_s2)
		else $error("decode stage did not advance");
`endif

endmodule
